@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg - preemptive priority scheduler package
// Table size, index widths and the entry/best-candidate record types.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        done;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] burst;
        logic [15:0] arrival;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_best;

endpackage

@@ rtl/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram - process table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/pps_scan.sv @@
// ----------------------------------------------------------------------------
// pps_scan - best candidate tracker
// Takes one table entry per cycle and keeps the ready entry with the lowest
// priority number; the first one seen wins a tie.
// ----------------------------------------------------------------------------
module pps_scan (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clr,
    input  logic                    i_chk,
    input  logic [pps_pkg::IDX_W-1:0] i_idx,
    input  pps_pkg::t_entry         i_entry,
    input  logic [15:0]             i_now,
    output pps_pkg::t_best          o_best
);
    import pps_pkg::*;

    t_best r_best;
    logic  eligible;
    logic  take;

    assign eligible = !i_entry.done && (i_entry.arrival <= i_now);
    assign take     = i_chk && eligible &&
                      (!r_best.found || (i_entry.prio < r_best.entry.prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_best.found <= 1'b0;
        end else if (take) begin
            r_best.found <= 1'b1;
        end
        if (take) begin
            r_best.idx   <= i_idx;
            r_best.entry <= i_entry;
        end
    end

    assign o_best = r_best;

endmodule

@@ rtl/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit - preemptive priority scheduler top level
// A load is taken in S_IDLE; a tick scans the table one entry per cycle
// through the single RAM read port before the result register is written.
// One transaction in flight.
// Reset (synchronous, active low) clears counts, time and control; the table
// RAM is not cleared, only slots below loaded_count are ever read.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_arrival_time,
    input  logic [15:0] i_burst_time,
    input  logic [7:0]  i_priority_level,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_slot_index,
    output logic        o_idle,
    output logic [15:0] o_slot_start,
    output logic        o_finished,
    output logic [15:0] o_completion_time,
    output logic [15:0] o_turnaround_time,
    output logic [15:0] o_waiting_time,
    output logic        o_all_done
);
    import pps_pkg::*;

    // Control FSM:
    //   S_IDLE - take a transaction; a load writes the table in place
    //   S_SCAN - stream table entries out of the RAM into the tracker
    //   S_DONE - run the winner one unit, write it back, publish the result
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_loaded, n_loaded;
    logic [CNT_W-1:0]  r_finished, n_finished;
    logic [15:0]       r_time, n_time;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_chk;
    logic [IDX_W-1:0]  r_chk_idx;

    logic              accept;
    logic              issue;
    logic              out_free;
    logic              retire;

    // table RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    t_best             best;

    // execution of the winner
    logic [15:0]       rem_next;
    logic              fin;
    logic [15:0]       comp;
    logic [15:0]       tat;
    logic [15:0]       wait_t;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign issue    = (r_state == S_SCAN) && (r_ptr < r_loaded);
    assign out_free = !o_valid || !i_stall;
    assign retire   = (r_state == S_DONE) && out_free;

    // Winner update: remaining time saturates at zero, so a zero burst
    // finishes on its first run just like a burst of one.
    assign rem_next = (best.entry.remaining != 16'd0) ?
                      best.entry.remaining - 16'd1 : 16'd0;
    assign fin      = best.found && (rem_next == 16'd0);
    assign comp     = r_time + 16'd1;
    assign tat      = comp - best.entry.arrival;
    assign wait_t   = tat - best.entry.burst;

    // RAM writes happen only in S_IDLE (load) and S_DONE (write-back), reads
    // only in S_SCAN, so no read can see a same-entry write in flight.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best.idx;
        ram_wdata = best.entry;
        if (r_state == S_IDLE) begin
            ram_waddr           = r_loaded[IDX_W-1:0];
            ram_wdata.done      = 1'b0;
            ram_wdata.prio      = i_priority_level;
            ram_wdata.remaining = i_burst_time;
            ram_wdata.burst     = i_burst_time;
            ram_wdata.arrival   = i_arrival_time;
            ram_we = accept && (i_kind == KIND_LOAD) &&
                     (r_loaded < CNT_W'(MAX_PROCESSES));
        end else if (retire && best.found) begin
            ram_we              = 1'b1;
            ram_wdata.remaining = rem_next;
            ram_wdata.done      = fin;
        end
    end

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Tracker sees RAM data in the cycle after the address was issued.
    pps_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (accept),
        .i_chk   (r_chk),
        .i_idx   (r_chk_idx),
        .i_entry (ram_rdata),
        .i_now   (r_time),
        .o_best  (best)
    );

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_finished = r_finished;
        n_time     = r_time;
        n_ptr      = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_TICK) begin
                        n_ptr   = '0;
                        n_state = S_SCAN;
                    end else if (ram_we) begin
                        n_loaded = r_loaded + CNT_W'(1);
                    end
                end
            end
            S_SCAN: begin
                // the last check, if any, lands in the tracker at this edge
                if (issue) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_time = comp;
                    if (fin) begin
                        n_finished = r_finished + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loaded   <= '0;
            r_finished <= '0;
            r_time     <= '0;
            r_ptr      <= '0;
            r_chk      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_finished <= n_finished;
            r_time     <= n_time;
            r_ptr      <= n_ptr;
            r_chk      <= issue;
        end
        r_chk_idx <= r_ptr[IDX_W-1:0];
    end

    // Result register: filled on retire, drained by the downstream handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (retire) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
        if (retire) begin
            o_slot_index      <= best.found ? 4'(best.idx) : 4'd0;
            o_idle            <= !best.found;
            o_slot_start      <= r_time;
            o_finished        <= fin;
            o_completion_time <= fin ? comp : 16'd0;
            o_turnaround_time <= fin ? tat : 16'd0;
            o_waiting_time    <= fin ? wait_t : 16'd0;
            o_all_done        <= (n_finished == r_loaded);
        end
    end

endmodule

@@ verif/preemptive_priority_scheduler_unit_test.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_test - scheduler unit regression bench
// Drives load and tick transactions through the valid/stall input channel,
// predicts every tick result from a behavioral copy of the process table and
// checks each result field against it. Covers an empty table, zero burst,
// priority ties, a late arrival, table overflow and long back-pressure on
// both channels.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_test;
    import pps_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 4000;  // watchdog: cycles without any transaction
    localparam int DRAIN_CYCLES = 40;    // settle time after the last result
    localparam int MAX_PRINTS   = 50;

    // one queued input transaction plus bench-side controls
    typedef struct packed {
        logic        kind;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        quiet;    // no random sender/receiver gaps while this one is live
        logic        squeeze;  // start a long receiver hold-off when accepted
        logic        drain;    // sender waits for all pending results first
    } t_sched_txn;

    typedef struct packed {
        logic [3:0]  slot;
        logic        idle;
        logic [15:0] start;
        logic        finished;
        logic [15:0] completion;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } t_slot_report;

    // ---------------------------------------------------------------- DUT I/O
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_stall;
    logic        in_kind = KIND_LOAD;
    logic [15:0] in_arrival = '0;
    logic [15:0] in_burst = '0;
    logic [7:0]  in_prio = '0;
    logic        in_squeeze = 1'b0;
    logic        o_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  o_slot_index;
    logic        o_idle;
    logic [15:0] o_slot_start;
    logic        o_finished;
    logic [15:0] o_completion_time;
    logic [15:0] o_turnaround_time;
    logic [15:0] o_waiting_time;
    logic        o_all_done;

    preemptive_priority_scheduler_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_stall           (o_stall),
        .i_kind            (in_kind),
        .i_arrival_time    (in_arrival),
        .i_burst_time      (in_burst),
        .i_priority_level  (in_prio),
        .o_valid           (o_valid),
        .i_stall           (out_stall),
        .o_slot_index      (o_slot_index),
        .o_idle            (o_idle),
        .o_slot_start      (o_slot_start),
        .o_finished        (o_finished),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_all_done        (o_all_done)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------ scheduler predictor
    // Own copy of the process table; slots at or above tbl_count are never read.
    logic [15:0] tbl_arrival   [MAX_PROCESSES];
    logic [15:0] tbl_burst     [MAX_PROCESSES];
    logic [15:0] tbl_remaining [MAX_PROCESSES];
    logic [7:0]  tbl_prio      [MAX_PROCESSES];
    logic        tbl_done      [MAX_PROCESSES];
    int          tbl_count = 0;
    int          done_count = 0;
    logic [15:0] sched_now = '0;

    t_sched_txn   pending_txn[$];   // stimulus not yet offered
    t_slot_report due_slots[$];     // predicted tick results, oldest first

    int mismatches = 0;

    // Apply one accepted transaction; a tick queues its predicted slot report.
    task automatic advance_scheduler(input t_sched_txn t);
        t_slot_report r;
        logic         found;
        int           best;
        int           i;
        logic [15:0]  span;
        if (t.kind == KIND_LOAD) begin
            // table full: load is dropped silently
            if (tbl_count < MAX_PROCESSES) begin
                tbl_arrival[tbl_count]   = t.arrival;
                tbl_burst[tbl_count]     = t.burst;
                tbl_remaining[tbl_count] = t.burst;
                tbl_prio[tbl_count]      = t.prio;
                tbl_done[tbl_count]      = 1'b0;
                tbl_count++;
            end
        end else begin
            found = 1'b0;
            best  = 0;
            // strict less-than keeps the lowest index on a priority tie
            for (i = 0; i < tbl_count; i++) begin
                if (!tbl_done[i] && tbl_arrival[i] <= sched_now) begin
                    if (!found || tbl_prio[i] < tbl_prio[best]) begin
                        found = 1'b1;
                        best  = i;
                    end
                end
            end
            r         = '0;
            r.start   = sched_now;
            sched_now = sched_now + 16'd1;   // wraps mod 2^16
            if (found) begin
                // zero burst: remaining never underflows, finishes on first run
                if (tbl_remaining[best] != 16'd0)
                    tbl_remaining[best] = tbl_remaining[best] - 16'd1;
                if (tbl_remaining[best] == 16'd0) begin
                    tbl_done[best] = 1'b1;
                    done_count++;
                    span         = sched_now - tbl_arrival[best];
                    r.finished   = 1'b1;
                    r.completion = sched_now;
                    r.turnaround = span;
                    r.waiting    = span - tbl_burst[best];
                end
                r.slot = best[3:0];
            end
            r.idle     = !found;
            r.all_done = (done_count == tbl_count);
            due_slots.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------ driver
    int   gap_left = 0;
    logic calm = 1'b0;   // follows the quiet flag of the last offered transaction

    always @(posedge i_clk) begin
        t_sched_txn t;
        logic       next_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && !o_stall) begin
                // transaction accepted at this edge
                t.kind    = in_kind;
                t.arrival = in_arrival;
                t.burst   = in_burst;
                t.prio    = in_prio;
                t.quiet   = calm;
                t.squeeze = in_squeeze;
                t.drain   = 1'b0;
                advance_scheduler(t);
                next_valid = 1'b0;
            end
            // a stalled payload is held; otherwise pick the next move
            if (!(in_valid && o_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else if (pending_txn.size() != 0) begin
                    if (pending_txn[0].drain && due_slots.size() != 0) begin
                        next_valid = 1'b0;   // pause until every result is back
                    end else if (!pending_txn[0].quiet && $urandom_range(0, 15) == 0) begin
                        gap_left   = $urandom_range(1, 11) - 1;
                        next_valid = 1'b0;
                    end else begin
                        t = pending_txn.pop_front();
                        in_kind    <= t.kind;
                        in_arrival <= t.arrival;
                        in_burst   <= t.burst;
                        in_prio    <= t.prio;
                        in_squeeze <= t.squeeze;
                        calm       <= t.quiet;
                        next_valid = 1'b1;
                    end
                end else begin
                    next_valid = 1'b0;
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------- long receiver hold-off
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (in_valid && !o_stall && in_squeeze)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ----------------------------------------------------------------- monitor
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_slot_report w;
        logic         next_stall;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                if (due_slots.size() == 0) begin
                    report_mismatch("unexpected result", o_slot_start, 0);
                end else begin
                    w = due_slots.pop_front();
                    if (o_slot_index !== w.slot)
                        report_mismatch("slot_index", o_slot_index, w.slot);
                    if (o_idle !== w.idle)
                        report_mismatch("idle", o_idle, w.idle);
                    if (o_slot_start !== w.start)
                        report_mismatch("slot_start", o_slot_start, w.start);
                    if (o_finished !== w.finished)
                        report_mismatch("finished", o_finished, w.finished);
                    if (o_completion_time !== w.completion)
                        report_mismatch("completion_time", o_completion_time, w.completion);
                    if (o_turnaround_time !== w.turnaround)
                        report_mismatch("turnaround_time", o_turnaround_time, w.turnaround);
                    if (o_waiting_time !== w.waiting)
                        report_mismatch("waiting_time", o_waiting_time, w.waiting);
                    if (o_all_done !== w.all_done)
                        report_mismatch("all_done", o_all_done, w.all_done);
                end
            end
            // back-pressure: long hold-off first, then random bursts
            if (hold_left != 0) begin
                next_stall = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                next_stall = 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                next_stall = 1'b1;
            end else begin
                next_stall = 1'b0;
            end
            out_stall <= next_stall;
        end
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("preemptive_priority_scheduler_unit regression: fail");
            $finish;
        end
    end

    // --------------------------------------------------------------- stimulus
    logic [15:0] gen_time = '0;   // scheduler time as the stimulus will leave it
    int          gen_loads = 0;

    task automatic queue_txn(input logic kind, input logic [15:0] arrival,
                             input logic [15:0] burst, input logic [7:0] prio,
                             input logic quiet, input logic squeeze, input logic drain);
        t_sched_txn t;
        t = '{kind, arrival, burst, prio, quiet, squeeze, drain};
        pending_txn.push_back(t);
        if (kind == KIND_TICK)
            gen_time = gen_time + 16'd1;
        else if (gen_loads < MAX_PROCESSES)
            gen_loads++;
    endtask

    task automatic queue_tick(input logic quiet, input logic squeeze, input logic drain);
        // a tick ignores the payload fields; fill them with noise
        queue_txn(KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
                  quiet, squeeze, drain);
    endtask

    initial begin
        int          counted;
        logic        quiet;
        logic [15:0] arr;
        logic [15:0] bst;
        logic [7:0]  pri;

        // directed: empty table, zero burst, tie, future arrival
        queue_tick(1'b0, 1'b0, 1'b0);         // nothing loaded -> idle, all done
        queue_txn(KIND_LOAD, 16'd0, 16'd0, 8'd128, 1'b0, 1'b0, 1'b0);  // zero burst
        queue_txn(KIND_LOAD, 16'd0, 16'd1, 8'd128, 1'b0, 1'b0, 1'b0);  // same prio
        queue_tick(1'b0, 1'b0, 1'b0);         // slot 0 wins the tie, finishes
        queue_tick(1'b0, 1'b0, 1'b0);         // slot 1 finishes
        queue_tick(1'b0, 1'b0, 1'b0);         // everything done -> idle
        queue_txn(KIND_LOAD, 16'd8, 16'd1, 8'd0, 1'b0, 1'b0, 1'b0);    // late arrival
        queue_txn(KIND_LOAD, 16'd5, 16'd2, 8'd255, 1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);         // nothing arrived yet
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);

        // first tick waits for a full drain; the late entry runs here
        queue_tick(1'b1, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0);

        // random: loads spread until the table is full, then ticks and dropped loads
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            quiet = (counted >= 800) || (counted >= 200 && counted < 220);
            if (gen_loads < MAX_PROCESSES && $urandom_range(0, 29) == 0) begin
                if ($urandom_range(0, 9) == 0)
                    arr = 16'($urandom);                     // far past or future
                else
                    arr = gen_time + 16'($urandom_range(0, 40));
                if ($urandom_range(0, 9) == 0)
                    bst = 16'($urandom_range(0, 1));
                else
                    bst = 16'($urandom_range(1, 60));
                if ($urandom_range(0, 2) == 0)
                    pri = 8'($urandom_range(0, 3));           // provoke ties
                else
                    pri = 8'($urandom_range(0, 255));
                if (gen_loads == MAX_PROCESSES - 1) begin
                    // last free slot: longest burst, lowest urgency, late arrival
                    arr = gen_time + 16'($urandom_range(100, 300));
                    bst = 16'hFFFF;
                    pri = 8'd255;
                end
                queue_txn(KIND_LOAD, arr, bst, pri, quiet, 1'b0, 1'b0);
                counted++;
            end else if (gen_loads >= MAX_PROCESSES && $urandom_range(0, 29) == 0) begin
                // table full: dropped, not counted
                queue_txn(KIND_LOAD, 16'($urandom), 16'($urandom), 8'($urandom),
                          quiet, 1'b0, 1'b0);
            end else begin
                queue_tick(quiet, (counted == 200) || (counted == 600), counted == 450);
                counted++;
            end
        end

        // reset: held low, then released synchronously
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_txn.size() == 0 && !in_valid);
        wait (due_slots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && due_slots.size() == 0)
            $display("preemptive_priority_scheduler_unit regression: pass");
        else
            $display("preemptive_priority_scheduler_unit regression: fail");
        $finish;
    end

endmodule
